@@ design/bben_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bben_pkg
// shared constants, types and states of the edge normalized box blur
// ----------------------------------------------------------------------------
package bben_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int MAX_RADIUS = 7;
    localparam int LINE_DEPTH = (2 * MAX_RADIUS + 1) * MAX_WIDTH + 2 * MAX_RADIUS + 1;
    localparam int ADDR_W     = $clog2(LINE_DEPTH);
    localparam int DIM_W      = 11;
    localparam int RAD_W      = 3;
    localparam int CNT_W      = 21;
    localparam int PIX_W      = 8;
    localparam int SUM_W      = 16;
    localparam int DIV_STAGES = 8;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_RADIUS = 2'd2;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_SETUP,
        S_READ,
        S_TAIL,
        S_WAIT
    } t_state;

    typedef struct packed {
        logic             vld;
        logic             last;
        logic [PIX_W-1:0] rem;
        logic [PIX_W-1:0] dq;
        logic [PIX_W-1:0] dvs;
    } t_div;

endpackage
`default_nettype wire

@@ design/box_blur_edge_normalized_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// box_blur_edge_normalized_top
// an item with a result passes the states start and setup, then reads its window
// one pixel a cycle from the single-port line store, then goes through tail, 8 divider cells and wait
// items without a result go from start straight back to idle; one item at a time
// reset: counters cleared, registers width 128, height 128, radius 0; line
// store contents undefined until written
// ----------------------------------------------------------------------------
module box_blur_edge_normalized_top (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire  [1:0]                   i_cfg_addr,
    input  wire  [bben_pkg::DIM_W-1:0]   i_cfg_data,
    input  wire                          i_s_tvalid,
    output logic                         o_s_tready,
    input  wire  [7:0]                   i_s_tdata,   // pixel_in
    input  wire                          i_s_tuser,   // command
    output logic                         o_m_tvalid,
    input  wire                          i_m_tready,
    output logic [7:0]                   o_m_tdata,   // pixel_out
    output logic                         o_m_tlast    // frame_last
);

    localparam int A = bben_pkg::ADDR_W;
    localparam int C = bben_pkg::CNT_W;
    localparam int D = bben_pkg::DIM_W;
    localparam logic [A:0] DEPTH = (A+1)'(bben_pkg::LINE_DEPTH);

    logic [bben_pkg::PIX_W-1:0] mem [bben_pkg::LINE_DEPTH];

    bben_pkg::t_state r_state, n_state;
    logic [D-1:0]   r_cfg_w, r_cfg_h;
    logic [2:0]     r_cfg_r;
    logic           r_cmd;
    logic [7:0]     r_pix;
    logic [C-1:0]   r_taken, r_given;
    logic [A-1:0]   r_wptr, r_gptr, r_addr;
    logic [D-2:0]   r_grow, r_gcol;
    logic [3:0]     r_xi, r_yi, r_nr, r_nc;
    logic [D-1:0]   r_step;
    logic [bben_pkg::SUM_W-1:0] r_sum;
    logic [7:0]     r_count;
    logic           r_last, r_rd_vld;
    logic [7:0]     r_rdata;
    logic           r_res_vld, r_res_last;
    logic [7:0]     r_res;

    logic [D-1:0]   w_w, w_h;
    logic [2:0]     w_r;
    logic [C-1:0]   w_total, w_lead, w_t_e, w_g_e;
    logic           w_restart, w_emit, w_out_free;
    logic [bben_pkg::SUM_W-1:0] w_sum_fin;
    bben_pkg::t_div w_div_in, w_div_out;

    // effective geometry
    always_comb begin
        w_w = (r_cfg_w == '0) ? D'(1) :
              (r_cfg_w > D'(bben_pkg::MAX_WIDTH)) ? D'(bben_pkg::MAX_WIDTH) : r_cfg_w;
        w_h = (r_cfg_h == '0) ? D'(1) :
              (r_cfg_h > D'(bben_pkg::MAX_HEIGHT)) ? D'(bben_pkg::MAX_HEIGHT) : r_cfg_h;
        w_r = (r_cfg_r > 3'(bben_pkg::MAX_RADIUS)) ? 3'(bben_pkg::MAX_RADIUS) : r_cfg_r;
        w_total   = C'(w_w * w_h);
        w_lead    = C'(w_r * w_w) + C'(w_r);
        w_restart = r_given >= w_total;
        w_t_e     = w_restart ? '0 : r_taken;
        w_g_e     = w_restart ? '0 : r_given;
        if (r_cmd == bben_pkg::CMD_PIXEL) begin
            w_emit = (w_t_e < w_total) && ((w_t_e + C'(1)) >= (w_g_e + w_lead + C'(1)));
        end else begin
            w_emit = w_t_e >= w_total;
        end
        w_out_free = !o_m_tvalid || i_m_tready;
        w_sum_fin  = r_sum + bben_pkg::SUM_W'(r_rdata);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= D'(128);
            r_cfg_h <= D'(128);
            r_cfg_r <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                bben_pkg::REG_WIDTH:  r_cfg_w <= i_cfg_data;
                bben_pkg::REG_HEIGHT: r_cfg_h <= i_cfg_data;
                bben_pkg::REG_RADIUS: r_cfg_r <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bben_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_s_tready = 1'b0;
        unique case (r_state)
            bben_pkg::S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) n_state = bben_pkg::S_START;
            end
            bben_pkg::S_START: begin
                n_state = w_emit ? bben_pkg::S_SETUP : bben_pkg::S_IDLE;
            end
            bben_pkg::S_SETUP: n_state = bben_pkg::S_READ;
            bben_pkg::S_READ: begin
                if (r_xi == r_nc - 4'd1 && r_yi == r_nr - 4'd1) n_state = bben_pkg::S_TAIL;
            end
            bben_pkg::S_TAIL: n_state = bben_pkg::S_WAIT;
            bben_pkg::S_WAIT: begin
                if (r_res_vld && w_out_free) n_state = bben_pkg::S_IDLE;
            end
            default: n_state = bben_pkg::S_IDLE;
        endcase
    end

    // line store
    always_ff @(posedge i_clk) begin
        if (r_state == bben_pkg::S_START && r_cmd == bben_pkg::CMD_PIXEL
            && w_t_e < w_total) begin
            mem[w_restart ? A'(0) : r_wptr] <= r_pix;
        end
        if (r_state == bben_pkg::S_READ) begin
            r_rdata <= mem[r_addr];
        end
    end

    // counters and window walk
    logic [3:0]   w_dr, w_dd, w_dc, w_de, w_nr, w_nc;
    logic [D-1:0] w_below, w_right;
    logic [A:0]   w_back, w_start, w_next, w_jump;
    logic [C-1:0] w_g1;

    always_comb begin
        w_dr    = (r_grow < (D-1)'(w_r)) ? 4'(r_grow) : 4'(w_r);
        w_dc    = (r_gcol < (D-1)'(w_r)) ? 4'(r_gcol) : 4'(w_r);
        w_below = w_h - D'(1) - D'(r_grow);
        w_right = w_w - D'(1) - D'(r_gcol);
        w_dd    = (w_below < D'(w_r)) ? 4'(w_below) : 4'(w_r);
        w_de    = (w_right < D'(w_r)) ? 4'(w_right) : 4'(w_r);
        w_nr    = w_dr + w_dd + 4'd1;
        w_nc    = w_dc + w_de + 4'd1;
        w_back  = (A+1)'(w_dr * w_w) + (A+1)'(w_dc);
        w_start = ({1'b0, r_gptr} >= w_back) ? {1'b0, r_gptr} - w_back
                                             : {1'b0, r_gptr} + DEPTH - w_back;
        w_next  = {1'b0, r_addr} + (A+1)'(1);
        w_jump  = {1'b0, r_addr} + (A+1)'(r_step);
        w_g1    = r_given + C'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taken  <= '0;
            r_given  <= '0;
            r_wptr   <= '0;
            r_gptr   <= '0;
            r_grow   <= '0;
            r_gcol   <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= (r_state == bben_pkg::S_READ);
            if (r_state == bben_pkg::S_IDLE && i_s_tvalid) begin
                r_cmd <= i_s_tuser;
                r_pix <= i_s_tdata;
            end
            if (r_state == bben_pkg::S_START) begin
                if (w_restart) begin
                    r_given <= '0;
                    r_gptr  <= '0;
                    r_grow  <= '0;
                    r_gcol  <= '0;
                end
                if (r_cmd == bben_pkg::CMD_PIXEL && w_t_e < w_total) begin
                    r_taken <= w_t_e + C'(1);
                    r_wptr  <= (w_restart ? A'(0) : r_wptr) == A'(DEPTH - 1) ? A'(0)
                             : (w_restart ? A'(1) : r_wptr + A'(1));
                end else begin
                    r_taken <= w_t_e;
                    if (w_restart) r_wptr <= '0;
                end
            end
            if (r_state == bben_pkg::S_SETUP) begin
                r_addr  <= A'(w_start);
                r_nr    <= w_nr;
                r_nc    <= w_nc;
                r_xi    <= '0;
                r_yi    <= '0;
                r_step  <= w_w - D'(w_nc) + D'(1);
                r_count <= 8'(w_nr * w_nc);
                r_sum   <= '0;
                if (w_g1 >= w_total) begin
                    r_last  <= 1'b1;
                    r_given <= '0;
                    r_taken <= '0;
                    r_wptr  <= '0;
                    r_gptr  <= '0;
                    r_grow  <= '0;
                    r_gcol  <= '0;
                end else begin
                    r_last  <= 1'b0;
                    r_given <= w_g1;
                    r_gptr  <= (r_gptr == A'(DEPTH - 1)) ? A'(0) : r_gptr + A'(1);
                    if (D'(r_gcol) + D'(1) == w_w) begin
                        r_gcol <= '0;
                        r_grow <= r_grow + (D-1)'(1);
                    end else begin
                        r_gcol <= r_gcol + (D-1)'(1);
                    end
                end
            end
            if (r_state == bben_pkg::S_READ) begin
                if (r_rd_vld) r_sum <= w_sum_fin;
                if (r_xi == r_nc - 4'd1) begin
                    r_xi   <= '0;
                    r_yi   <= r_yi + 4'd1;
                    r_addr <= (w_jump >= DEPTH) ? A'(w_jump - DEPTH) : A'(w_jump);
                end else begin
                    r_xi   <= r_xi + 4'd1;
                    r_addr <= (w_next >= DEPTH) ? A'(w_next - DEPTH) : A'(w_next);
                end
            end
        end
    end

    always_comb begin
        w_div_in.vld  = (r_state == bben_pkg::S_TAIL);
        w_div_in.last = r_last;
        w_div_in.rem  = w_sum_fin[bben_pkg::SUM_W-1:bben_pkg::PIX_W];
        w_div_in.dq   = w_sum_fin[bben_pkg::PIX_W-1:0];
        w_div_in.dvs  = r_count;
    end

    bben_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_d     (w_div_in),
        .o_d     (w_div_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_vld  <= 1'b0;
            o_m_tvalid <= 1'b0;
        end else begin
            if (w_div_out.vld) begin
                r_res_vld  <= 1'b1;
                r_res      <= w_div_out.dq;
                r_res_last <= w_div_out.last;
            end else if (r_state == bben_pkg::S_WAIT && r_res_vld && w_out_free) begin
                r_res_vld <= 1'b0;
            end
            if (r_state == bben_pkg::S_WAIT && r_res_vld && w_out_free) begin
                o_m_tvalid <= 1'b1;
                o_m_tdata  <= r_res;
                o_m_tlast  <= r_res_last;
            end else if (i_m_tready) begin
                o_m_tvalid <= 1'b0;
            end
        end
    end

    a_div_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_out.vld |-> r_state == bben_pkg::S_WAIT)
        else $error("divider result outside wait state");

    a_addr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == bben_pkg::S_READ |-> {1'b0, r_addr} < DEPTH)
        else $error("line store address out of range");

    a_given_le_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_given <= r_taken)
        else $error("more outputs than pixels");

endmodule
`default_nettype wire

@@ design/bben_div_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bben_div_cell
// one restoring division step, registered, handed to the next cell
// ----------------------------------------------------------------------------
module bben_div_cell (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  bben_pkg::t_div     i_d,
    output bben_pkg::t_div     o_d
);

    logic [bben_pkg::PIX_W:0]   w_trial;
    logic                       w_ge;
    logic [bben_pkg::PIX_W:0]   w_diff;
    bben_pkg::t_div             n_d;
    bben_pkg::t_div             r_d;

    always_comb begin
        w_trial = {i_d.rem, i_d.dq[bben_pkg::PIX_W-1]};
        w_ge    = w_trial >= {1'b0, i_d.dvs};
        w_diff  = w_trial - {1'b0, i_d.dvs};
        n_d      = i_d;
        n_d.rem  = w_ge ? w_diff[bben_pkg::PIX_W-1:0] : w_trial[bben_pkg::PIX_W-1:0];
        n_d.dq   = {i_d.dq[bben_pkg::PIX_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.vld <= 1'b0;
        end else begin
            r_d.vld <= n_d.vld;
        end
        r_d.last <= n_d.last;
        r_d.rem  <= n_d.rem;
        r_d.dq   <= n_d.dq;
        r_d.dvs  <= n_d.dvs;
    end

    assign o_d = r_d;

endmodule
`default_nettype wire

@@ design/bben_divider.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bben_divider
// row of division cells, window sum over pixel count, one quotient bit per cell
// ----------------------------------------------------------------------------
module bben_divider (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  bben_pkg::t_div     i_d,
    output bben_pkg::t_div     o_d
);

    bben_pkg::t_div w_link [bben_pkg::DIV_STAGES+1];

    assign w_link[0] = i_d;

    for (genvar g = 0; g < bben_pkg::DIV_STAGES; g++) begin : g_cell
        bben_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_d     (w_link[g]),
            .o_d     (w_link[g+1])
        );
    end

    assign o_d = w_link[bben_pkg::DIV_STAGES];

endmodule
`default_nettype wire

@@ verif/box_blur_edge_normalized_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_blur_edge_normalized_top_tb
// self-checking bench for the edge normalized box blur: frames of random
// pixels are streamed under several geometries and radii, each output pixel
// is compared with a mean computed here over the in-frame window, with
// random gaps on the input side and random stalls on the output side
// ----------------------------------------------------------------------------
module box_blur_edge_normalized_top_tb;
    import bben_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int IDLE_WAIT   = 20;
    localparam int END_WAIT    = 300;

    typedef struct {
        logic [7:0] pix;
        logic       last;
    } t_blur_px;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [1:0]       i_cfg_addr;
    logic [DIM_W-1:0] i_cfg_data;
    logic             i_s_tvalid;
    logic             o_s_tready;
    logic [7:0]       i_s_tdata;
    logic             i_s_tuser;
    logic             o_m_tvalid;
    logic             i_m_tready;
    logic [7:0]       o_m_tdata;
    logic             o_m_tlast;

    box_blur_edge_normalized_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    // local copy of the filter state
    logic [7:0]       pix_store [LINE_DEPTH];
    int unsigned      n_taken;
    int unsigned      n_given;
    logic [DIM_W-1:0] cur_width;
    logic [DIM_W-1:0] cur_height;
    logic [RAD_W-1:0] cur_radius;

    t_blur_px blur_q[$];
    int       n_errors;
    int       n_requests;
    int       cycle_cnt;
    int       rdy_hold;
    bit       no_idle;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic int unsigned eff_width();
        if (cur_width < 1) return 1;
        if (cur_width > MAX_WIDTH) return MAX_WIDTH;
        return cur_width;
    endfunction

    function automatic int unsigned eff_height();
        if (cur_height < 1) return 1;
        if (cur_height > MAX_HEIGHT) return MAX_HEIGHT;
        return cur_height;
    endfunction

    function automatic int unsigned eff_radius();
        return (cur_radius > MAX_RADIUS) ? MAX_RADIUS : cur_radius;
    endfunction

    function automatic logic [7:0] window_avg(int unsigned m, int unsigned w,
                                              int unsigned h, int unsigned r);
        int unsigned row, col, r0, r1, c0, c1, sum, cnt;
        row = m / w;
        col = m % w;
        r0  = (row > r) ? row - r : 0;
        r1  = (row + r < h - 1) ? row + r : h - 1;
        c0  = (col > r) ? col - r : 0;
        c1  = (col + r < w - 1) ? col + r : w - 1;
        sum = 0;
        cnt = 0;
        for (int unsigned y = r0; y <= r1; y++) begin
            for (int unsigned x = c0; x <= c1; x++) begin
                sum += pix_store[(y * w + x) % LINE_DEPTH];
                cnt++;
            end
        end
        return (sum / cnt) & 8'hff;
    endfunction

    function automatic void emit_blur(int unsigned w, int unsigned h, int unsigned r,
                                      int unsigned total);
        t_blur_px px;
        px.pix  = window_avg(n_given, w, h, r);
        px.last = 1'b0;
        n_given++;
        if (n_given >= total) begin
            px.last = 1'b1;
            n_given = 0;
            n_taken = 0;
        end
        blur_q.push_back(px);
    endfunction

    function automatic void predict_blur(logic cmd, logic [7:0] pix);
        int unsigned w, h, r, total, lead;
        w     = eff_width();
        h     = eff_height();
        r     = eff_radius();
        total = w * h;
        lead  = r * w + r;
        if (n_given >= total) begin
            n_given = 0;
            n_taken = 0;
        end
        if (cmd == CMD_PIXEL) begin
            if (n_taken < total) begin
                pix_store[n_taken % LINE_DEPTH] = pix;
                n_taken++;
                if (n_taken >= n_given + lead + 1) emit_blur(w, h, r, total);
            end
        end else if (n_taken >= total) begin
            emit_blur(w, h, r, total);
        end
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycle_cnt);
        n_errors++;
    endtask

    // output side stalls
    always @(negedge i_clk) begin
        if (rdy_hold > 0) begin
            i_m_tready <= 1'b0;
            rdy_hold   <= rdy_hold - 1;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_blur_px want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            rdy_hold <= no_idle ? 0 : $urandom_range(0, 3);
            if (blur_q.size() == 0) begin
                report_mismatch("unexpected pixel", o_m_tdata, -1);
            end else begin
                want = blur_q.pop_front();
                if (o_m_tdata !== want.pix) report_mismatch("pixel_out", o_m_tdata, want.pix);
                if (o_m_tlast !== want.last) report_mismatch("frame_last", o_m_tlast, want.last);
            end
        end
    end

    task automatic send_item(logic cmd, logic [7:0] pix);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= pix;
        i_s_tuser  <= cmd;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        predict_blur(cmd, pix);
        n_requests++;
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        while (blur_q.size() != 0) @(negedge i_clk);
        repeat (IDLE_WAIT) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [DIM_W-1:0] val);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            REG_WIDTH:  cur_width  = val;
            REG_HEIGHT: cur_height = val;
            REG_RADIUS: cur_radius = val[RAD_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_geometry(int w, int h, int r);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        write_reg(REG_RADIUS, r);
    endtask

    // drain requests until the frame counters are back at zero
    task automatic flush_frame();
        while (n_taken != 0) send_item(CMD_DRAIN, $urandom_range(0, 255));
    endtask

    task automatic stream_frame(int noise_pct);
        int total;
        total = eff_width() * eff_height();
        for (int k = 0; k < total; k++) begin
            if ($urandom_range(0, 99) < noise_pct) send_item(CMD_DRAIN, $urandom_range(0, 255));
            send_item(CMD_PIXEL, $urandom_range(0, 255));
        end
        if ($urandom_range(0, 99) < noise_pct && n_taken != 0) begin
            repeat ($urandom_range(1, 3)) send_item(CMD_PIXEL, $urandom_range(0, 255));
        end
        flush_frame();
    endtask

    task automatic test_passthrough();
        set_geometry(4, 2, 0);
        send_item(CMD_PIXEL, 8'h00);
        send_item(CMD_PIXEL, 8'hff);
        repeat (6) send_item(CMD_PIXEL, $urandom_range(0, 255));
        flush_frame();
    endtask

    task automatic test_edges();
        set_geometry(3, 3, 1);
        for (int k = 0; k < 9; k++) send_item(CMD_PIXEL, (k % 2) ? 8'hff : 8'h00);
        flush_frame();
        set_geometry(2, 2, 7);
        stream_frame(0);
    endtask

    task automatic test_geometry();
        set_geometry(0, 0, 2);
        send_item(CMD_PIXEL, 8'hff);
        flush_frame();
        set_geometry(2047, 1, 3);
        stream_frame(0);
        set_geometry(1, 4, 5);
        stream_frame(0);
    endtask

    task automatic test_idle_drain();
        set_geometry(3, 2, 1);
        send_item(CMD_DRAIN, 8'h00);
        repeat (3) send_item(CMD_PIXEL, $urandom_range(0, 255));
        send_item(CMD_DRAIN, 8'hff);
        repeat (3) send_item(CMD_PIXEL, $urandom_range(0, 255));
        // frame complete, these pixels are dropped
        send_item(CMD_PIXEL, 8'h5a);
        send_item(CMD_PIXEL, 8'ha5);
        flush_frame();
        send_item(CMD_DRAIN, 8'h00);
    endtask

    task automatic test_shrunk_frame();
        set_geometry(1, 2047, 0);
        repeat (12) send_item(CMD_PIXEL, $urandom_range(0, 255));
        write_reg(REG_HEIGHT, 4);
        stream_frame(0);
    endtask

    task automatic test_backlog();
        set_geometry(4, 4, 1);
        repeat (8) send_item(CMD_PIXEL, $urandom_range(0, 255));
        write_reg(REG_RADIUS, 0);
        repeat (8) send_item(CMD_PIXEL, $urandom_range(0, 255));
        flush_frame();
    endtask

    task automatic test_random();
        while (n_requests < 1700) begin
            no_idle = ($urandom_range(0, 5) == 0);
            set_geometry($urandom_range(1, 6), $urandom_range(1, 5), $urandom_range(0, 7));
            stream_frame($urandom_range(0, 4) == 0 ? 15 : 0);
        end
        no_idle = 0;
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_addr = REG_WIDTH;
        i_cfg_data = '0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = CMD_PIXEL;
        i_m_tready = 1'b0;
        n_taken    = 0;
        n_given    = 0;
        cur_width  = 128;
        cur_height = 128;
        cur_radius = 0;
        n_errors   = 0;
        n_requests = 0;
        cycle_cnt  = 0;
        rdy_hold   = 0;
        no_idle    = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_passthrough();
        test_edges();
        test_geometry();
        test_idle_drain();
        test_shrunk_frame();
        test_backlog();
        test_random();

        i_s_tvalid <= 1'b0;
        while (blur_q.size() != 0) @(negedge i_clk);
        repeat (END_WAIT) @(negedge i_clk);
        if (n_errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
